// ===== rtl/cta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cta_pkg: shared types and constants for the time zone adjust pipeline
// Stage payload structs, calendar constants and the month length lookup.
// ----------------------------------------------------------------------------
package cta_pkg;

   localparam logic [6:0]  HoursPerDay = 7'd24;
   localparam logic [3:0]  MonthJan    = 4'd1;
   localparam logic [3:0]  MonthFeb    = 4'd2;
   localparam logic [3:0]  MonthApr    = 4'd4;
   localparam logic [3:0]  MonthJun    = 4'd6;
   localparam logic [3:0]  MonthSep    = 4'd9;
   localparam logic [3:0]  MonthNov    = 4'd11;
   localparam logic [3:0]  MonthDec    = 4'd12;
   localparam logic [4:0]  DaysLeapFeb = 5'd29;
   localparam logic [4:0]  DaysFeb     = 5'd28;
   localparam logic [4:0]  DaysShort   = 5'd30;
   localparam logic [4:0]  DaysLong    = 5'd31;

   // multiplicative inverse of 25 modulo 2^12; x*Inv25 mod 2^12 <= Mult25Max
   // exactly when x is a multiple of 25
   localparam logic [11:0] Inv25       = 12'd3113;
   localparam logic [11:0] Mult25Max   = 12'd163;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        time_ok;
      logic        date_ok;
      logic [6:0]  hour_sum;
      logic [11:0] prod4;
      logic [11:0] prod16;
   } cta_s1_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [4:0]  hour_adj;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [6:0]  day_adj;
      logic [3:0]  month;
      logic [13:0] year;
      logic        leap;
      logic [4:0]  len_cur;
      logic        time_ok;
      logic        date_ok;
   } cta_s2_type;

   typedef struct packed {
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [13:0] year;
      logic        time_ok;
      logic        date_ok;
   } cta_out_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      if (m == MonthFeb) begin
         len = leap ? DaysLeapFeb : DaysFeb;
      end else if (m inside {MonthApr, MonthJun, MonthSep, MonthNov}) begin
         len = DaysShort;
      end else begin
         len = DaysLong;
      end
      return len;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cta_month_roll.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cta_month_roll: day borrow and carry into month and year
// Resolves a shifted day against month length, selects raw or adjusted fields.
// ----------------------------------------------------------------------------
module cta_month_roll
   import cta_pkg::*;
(
   input  cta_s2_type  s2,
   output cta_out_type result
);

   logic        both_ok;
   logic        borrow;
   logic        carry;
   logic        month_lo;
   logic        month_hi;
   logic [3:0]  prev_month;
   logic [3:0]  next_month;
   logic [13:0] prev_year;
   logic [13:0] next_year;
   logic [4:0]  prev_len;
   logic [4:0]  day_carry;

   assign both_ok    = s2.time_ok & s2.date_ok;
   assign borrow     = s2.day_adj[6] | (s2.day_adj == 7'd0);
   assign carry      = !borrow && (s2.day_adj > {2'b00, s2.len_cur});

   assign month_lo   = (s2.month == 4'd0) || (s2.month == MonthJan);
   assign month_hi   = (s2.month >= MonthDec);
   assign prev_month = month_lo ? MonthDec : s2.month - 4'd1;
   assign prev_year  = month_lo ? s2.year - 14'd1 : s2.year;
   assign next_month = month_hi ? MonthJan : s2.month + 4'd1;
   assign next_year  = month_hi ? s2.year + 14'd1 : s2.year;
   assign prev_len   = month_len(prev_month, s2.leap);
   assign day_carry  = s2.day_adj[4:0] - s2.len_cur;

   always_comb begin
      result.minute  = s2.minute;
      result.second  = s2.second;
      result.time_ok = s2.time_ok;
      result.date_ok = s2.date_ok;
      result.hour    = s2.hour;
      result.day     = s2.day;
      result.month   = s2.month;
      result.year    = s2.year;
      if (both_ok) begin
         result.hour = s2.hour_adj;
         if (borrow) begin
            result.day   = prev_len;
            result.month = prev_month;
            result.year  = prev_year;
         end else if (carry) begin
            result.day   = day_carry;
            result.month = next_month;
            result.year  = next_year;
         end else begin
            result.day = s2.day_adj[4:0];
         end
      end
   end

endmodule
`default_nettype wire

// ===== rtl/calendar_timezone_adjust.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// calendar_timezone_adjust: UTC to local time and date
// Adds a signed hour offset and rolls day, month and year on the Gregorian
// calendar. Fields pass through raw unless both valid flags are set.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_stall   utc time, date, flags
//   rsp      out        rsp_valid / rsp_stall   local time, date, flags
//   csr      in         csr_wr_en               signed hour offset
//
// Three register stages: hour sum and leap products, hour wrap and month
// length, then day roll into the output register. One beat is taken every
// cycle while req_stall is low. Each stage fills when empty, so a stall
// on rsp backs up into req only once all three stages hold a beat. Reset
// clears the stage valid bits and the offset register.
// ----------------------------------------------------------------------------
module calendar_timezone_adjust
   import cta_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [4:0]  csr_wr_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [4:0]  req_utc_hour,
   input  wire logic [5:0]  req_utc_minute,
   input  wire logic [5:0]  req_utc_second,
   input  wire logic [4:0]  req_utc_day,
   input  wire logic [3:0]  req_utc_month,
   input  wire logic [13:0] req_utc_year,
   input  wire logic        req_time_ok,
   input  wire logic        req_date_ok,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_local_hour,
   output logic [5:0]       rsp_local_minute,
   output logic [5:0]       rsp_local_second,
   output logic [4:0]       rsp_local_day,
   output logic [3:0]       rsp_local_month,
   output logic [13:0]      rsp_local_year,
   output logic             rsp_time_shown,
   output logic             rsp_date_shown
);

   logic [4:0]  tz_ff;
   logic        v1_ff, v2_ff, v3_ff;
   logic        rdy1, rdy2, rdy3;
   cta_s1_type  s1_in, s1_ff;
   cta_s2_type  s2_in, s2_ff;
   cta_out_type s3_in, s3_ff;
   logic        hour_neg, hour_over;
   logic [6:0]  sum_plus, sum_minus;

   assign rdy3      = !v3_ff || !rsp_stall;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_stall = !rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tz_ff <= 5'd0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            tz_ff <= csr_wr_data;
         end
         if (rdy1) begin
            v1_ff <= req_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // stage 1: raw capture, hour sum, scaled year for the century tests
   always_comb begin
      s1_in.hour     = req_utc_hour;
      s1_in.minute   = req_utc_minute;
      s1_in.second   = req_utc_second;
      s1_in.day      = req_utc_day;
      s1_in.month    = req_utc_month;
      s1_in.year     = req_utc_year;
      s1_in.time_ok  = req_time_ok;
      s1_in.date_ok  = req_date_ok;
      s1_in.hour_sum = {2'b00, req_utc_hour} + {{2{tz_ff[4]}}, tz_ff};
      s1_in.prod4    = req_utc_year[13:2] * Inv25;
      s1_in.prod16   = {2'b00, req_utc_year[13:4]} * Inv25;
   end

   // stage 2: hour wrap, day shift, leap year, length of the current month
   assign hour_neg  = s1_ff.hour_sum[6];
   assign hour_over = !hour_neg && (s1_ff.hour_sum >= HoursPerDay);
   assign sum_plus  = s1_ff.hour_sum + HoursPerDay;
   assign sum_minus = s1_ff.hour_sum - HoursPerDay;

   always_comb begin
      s2_in.hour    = s1_ff.hour;
      s2_in.minute  = s1_ff.minute;
      s2_in.second  = s1_ff.second;
      s2_in.day     = s1_ff.day;
      s2_in.month   = s1_ff.month;
      s2_in.year    = s1_ff.year;
      s2_in.time_ok = s1_ff.time_ok;
      s2_in.date_ok = s1_ff.date_ok;
      s2_in.leap    = (s1_ff.year[1:0] == 2'b00)
                      && ((s1_ff.prod4 > Mult25Max)
                          || ((s1_ff.year[3:0] == 4'd0) && (s1_ff.prod16 <= Mult25Max)));
      s2_in.len_cur = month_len(s1_ff.month, s2_in.leap);
      if (hour_neg) begin
         s2_in.hour_adj = sum_plus[4:0];
         s2_in.day_adj  = {2'b00, s1_ff.day} - 7'd1;
      end else if (hour_over) begin
         s2_in.hour_adj = sum_minus[4:0];
         s2_in.day_adj  = {2'b00, s1_ff.day} + 7'd1;
      end else begin
         s2_in.hour_adj = s1_ff.hour_sum[4:0];
         s2_in.day_adj  = {2'b00, s1_ff.day};
      end
   end

   // stage 3: day roll into month and year
   cta_month_roll u_month_roll (
      .s2     (s2_ff),
      .result (s3_in)
   );

   always_ff @(posedge clock) begin
      if (rdy1) begin
         s1_ff <= s1_in;
      end
      if (rdy2) begin
         s2_ff <= s2_in;
      end
      if (rdy3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_valid        = v3_ff;
   assign rsp_local_hour   = s3_ff.hour;
   assign rsp_local_minute = s3_ff.minute;
   assign rsp_local_second = s3_ff.second;
   assign rsp_local_day    = s3_ff.day;
   assign rsp_local_month  = s3_ff.month;
   assign rsp_local_year   = s3_ff.year;
   assign rsp_time_shown   = s3_ff.time_ok;
   assign rsp_date_shown   = s3_ff.date_ok;

endmodule
`default_nettype wire

// ===== rtl/cta_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cta_checker: port level checks for calendar_timezone_adjust
// Watches reset, back pressure and the range of adjusted results.
// ----------------------------------------------------------------------------
module cta_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [4:0]  rsp_local_hour,
   input wire logic [5:0]  rsp_local_minute,
   input wire logic [5:0]  rsp_local_second,
   input wire logic [4:0]  rsp_local_day,
   input wire logic [3:0]  rsp_local_month,
   input wire logic [13:0] rsp_local_year,
   input wire logic        rsp_time_shown,
   input wire logic        rsp_date_shown
);

   // empty pipeline after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // back pressure reaches req only from a stalled rsp beat
   a_stall_source: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without stalled rsp beat");

   // adjusted beats carry a wrapped hour and a nonzero day
   a_adjusted_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_time_shown && rsp_date_shown)
         |-> ((rsp_local_hour < 5'd24) && (rsp_local_day != 5'd0)))
      else $error("adjusted beat out of range");

   // stalled rsp beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid
         && $stable(rsp_local_hour) && $stable(rsp_local_minute)
         && $stable(rsp_local_second) && $stable(rsp_local_day)
         && $stable(rsp_local_month) && $stable(rsp_local_year)
         && $stable(rsp_time_shown) && $stable(rsp_date_shown)))
      else $error("stalled rsp beat changed");

endmodule

bind calendar_timezone_adjust cta_checker u_cta_checker (.*);
`default_nettype wire

// ===== verif/tb_calendar_timezone_adjust.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_calendar_timezone_adjust: self-checking bench for the time zone adjust
// Drives UTC beats in random bursts and rewrites the hour offset between
// phases while the pipeline is empty. Each beat is predicted on acceptance,
// and every local beat is compared field by field against the oldest
// prediction under random and long receiver stalls.
// ----------------------------------------------------------------------------
module tb_calendar_timezone_adjust
   import cta_pkg::*;
();

   localparam int SettleCycles = 4;
   localparam int TailCycles   = 10;
   localparam int HoldCycles   = 80;
   localparam int HoldAfter    = 150;

   typedef enum logic [1:0] {KindBeat, KindWrite, KindDrain} pend_kind_type;
   typedef enum int {StallNone, StallRandom, StallPeriodic, StallHeavy} stall_mode_type;

   typedef struct packed {
      pend_kind_type kind;
      logic [4:0]    wr_value;
      logic [4:0]    hour;
      logic [5:0]    minute;
      logic [5:0]    second;
      logic [4:0]    day;
      logic [3:0]    month;
      logic [13:0]   year;
      logic          time_ok;
      logic          date_ok;
   } utc_beat_type;

   logic        clock;
   logic        reset            = 1'b1;
   logic        csr_wr_en        = 1'b0;
   logic [4:0]  csr_wr_data      = '0;
   logic        req_valid        = 1'b0;
   logic        req_stall;
   logic [4:0]  req_utc_hour     = '0;
   logic [5:0]  req_utc_minute   = '0;
   logic [5:0]  req_utc_second   = '0;
   logic [4:0]  req_utc_day      = '0;
   logic [3:0]  req_utc_month    = '0;
   logic [13:0] req_utc_year     = '0;
   logic        req_time_ok      = 1'b0;
   logic        req_date_ok      = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall        = 1'b0;
   logic [4:0]  rsp_local_hour;
   logic [5:0]  rsp_local_minute;
   logic [5:0]  rsp_local_second;
   logic [4:0]  rsp_local_day;
   logic [3:0]  rsp_local_month;
   logic [13:0] rsp_local_year;
   logic        rsp_time_shown;
   logic        rsp_date_shown;

   utc_beat_type      pend_q[$];
   cta_out_type       local_q[$];
   utc_beat_type      cur_beat    = '0;
   logic signed [4:0] tz_offset   = '0;
   int                err_cnt     = 0;
   int                gap_cnt     = 0;
   int                burst_cnt   = 0;
   int                quiet_cnt   = 0;
   int                settle_cnt  = 0;
   int                hold_cnt    = 0;
   bit                hold_done   = 1'b0;
   int                got_cnt     = 0;
   int                mode_cnt    = 0;
   int                phase_cnt   = 0;
   stall_mode_type    stall_mode  = StallNone;

   calendar_timezone_adjust u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_utc_hour     (req_utc_hour),
      .req_utc_minute   (req_utc_minute),
      .req_utc_second   (req_utc_second),
      .req_utc_day      (req_utc_day),
      .req_utc_month    (req_utc_month),
      .req_utc_year     (req_utc_year),
      .req_time_ok      (req_time_ok),
      .req_date_ok      (req_date_ok),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_local_hour   (rsp_local_hour),
      .rsp_local_minute (rsp_local_minute),
      .rsp_local_second (rsp_local_second),
      .rsp_local_day    (rsp_local_day),
      .rsp_local_month  (rsp_local_month),
      .rsp_local_year   (rsp_local_year),
      .rsp_time_shown   (rsp_time_shown),
      .rsp_date_shown   (rsp_date_shown)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic bit leap_year(input int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic int month_days(input int m, input int unsigned y);
      if (m == 2) begin
         return leap_year(y) ? 29 : 28;
      end
      if (m == 4 || m == 6 || m == 9 || m == 11) begin
         return 30;
      end
      return 31;
   endfunction

   function automatic cta_out_type local_from_utc(input utc_beat_type b,
                                                  input logic signed [4:0] ofs);
      cta_out_type r;
      int          h;
      int          d;
      int          m;
      int unsigned y;
      h = int'(b.hour);
      d = int'(b.day);
      m = int'(b.month);
      y = 32'(b.year);
      if (b.time_ok && b.date_ok) begin
         h = h + int'(ofs);
         if (h < 0) begin
            h = h + 24;
            d = d - 1;
         end else if (h >= 24) begin
            h = h - 24;
            d = d + 1;
         end
         if (d < 1) begin
            m = m - 1;
            if (m < 1) begin
               m = 12;
               y = (y - 1) & 32'h3FFF;
            end
            d = month_days(m, y);
         end else if (d > month_days(m, y)) begin
            d = d - month_days(m, y);
            m = m + 1;
            if (m > 12) begin
               m = 1;
               y = (y + 1) & 32'h3FFF;
            end
         end
      end
      r.hour    = h[4:0];
      r.minute  = b.minute;
      r.second  = b.second;
      r.day     = d[4:0];
      r.month   = m[3:0];
      r.year    = y[13:0];
      r.time_ok = b.time_ok;
      r.date_ok = b.date_ok;
      return r;
   endfunction

   task automatic push_beat(input int h, input int mi, input int s, input int d,
                            input int mo, input int y, input bit t_ok, input bit d_ok);
      utc_beat_type b;
      b          = '0;
      b.kind     = KindBeat;
      b.hour     = h[4:0];
      b.minute   = mi[5:0];
      b.second   = s[5:0];
      b.day      = d[4:0];
      b.month    = mo[3:0];
      b.year     = y[13:0];
      b.time_ok  = t_ok;
      b.date_ok  = d_ok;
      pend_q.push_back(b);
   endtask

   task automatic push_offset_write(input int v);
      utc_beat_type b;
      b          = '0;
      b.kind     = KindWrite;
      b.wr_value = v[4:0];
      pend_q.push_back(b);
   endtask

   task automatic push_drain();
      utc_beat_type b;
      b      = '0;
      b.kind = KindDrain;
      pend_q.push_back(b);
   endtask

   task automatic check_field(input string fname, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t %s: expected %0d actual %0d", $time, fname, exp_v, act_v);
         err_cnt++;
      end
   endtask

   initial begin : stim_proc
      int offsets[6];
      int h;
      int mi;
      int s;
      int d;
      int mo;
      int y;
      bit t_ok;
      bit d_ok;

      push_offset_write(14);
      push_beat(23, 59, 59, 31, 12, 9998, 1, 1);
      push_beat(10, 0, 0, 28, 2, 1900, 1, 1);
      push_beat(10, 1, 2, 28, 2, 2000, 1, 1);
      push_beat(10, 3, 4, 29, 2, 2024, 1, 1);
      push_beat(12, 5, 6, 30, 4, 2023, 1, 1);
      push_beat(23, 7, 8, 31, 12, 16383, 1, 1);
      push_beat(20, 9, 10, 5, 0, 2023, 1, 1);
      push_beat(20, 11, 12, 31, 15, 2023, 1, 1);
      push_beat(20, 13, 14, 31, 2, 2023, 1, 1);
      push_beat(31, 15, 16, 0, 7, 2023, 1, 1);
      push_beat(0, 0, 0, 1, 1, 1, 0, 1);
      push_beat(23, 59, 59, 31, 12, 9998, 1, 0);
      push_beat(31, 63, 63, 31, 15, 16383, 0, 0);
      push_offset_write(-12);
      push_beat(0, 0, 0, 1, 1, 2023, 1, 1);
      push_beat(5, 30, 30, 1, 3, 2100, 1, 1);
      push_beat(5, 30, 30, 1, 3, 2000, 1, 1);
      push_beat(3, 1, 1, 1, 1, 0, 1, 1);
      push_beat(3, 2, 2, 1, 0, 2023, 1, 1);
      push_beat(3, 4, 4, 0, 5, 2023, 1, 1);
      push_beat(23, 45, 45, 31, 12, 2023, 1, 1);
      push_offset_write(-16);
      push_beat(0, 10, 20, 1, 5, 1999, 1, 1);
      push_beat(31, 10, 20, 15, 8, 1999, 1, 1);
      push_offset_write(15);
      push_beat(31, 59, 0, 31, 12, 16383, 1, 1);
      push_beat(8, 0, 59, 30, 6, 2001, 1, 1);

      offsets = '{0, 14, -12, 15, -16, 5};
      offsets[5] = int'($urandom_range(0, 26)) - 12;
      foreach (offsets[p]) begin
         push_offset_write(offsets[p]);
         for (int i = 0; i < 100; i++) begin
            if (p == 2 && i == 50) begin
               push_drain();
            end
            h  = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 31) : $urandom_range(0, 23);
            mi = $urandom_range(0, 59);
            s  = $urandom_range(0, 59);
            case ($urandom_range(0, 7))
               0:       d = 1;
               1, 2:    d = $urandom_range(28, 31);
               3:       d = $urandom_range(0, 1) ? 0 : 31;
               default: d = $urandom_range(1, 31);
            endcase
            mo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
            if ($urandom_range(0, 3) == 0) begin
               d  = $urandom_range(0, 1) ? 1 : $urandom_range(28, 29);
               mo = $urandom_range(0, 1) ? 3 : 2;
            end
            case ($urandom_range(0, 7))
               0:       y = $urandom_range(16, 24) * 100;
               1:       y = $urandom_range(0, 1) ? 0 : 16383;
               2:       y = $urandom_range(0, 16383);
               3:       y = $urandom_range(500, 2499) * 4;
               default: y = $urandom_range(1, 9998);
            endcase
            if ($urandom_range(0, 3) != 0) begin
               t_ok = 1'b1;
               d_ok = 1'b1;
            end else begin
               t_ok = 1'($urandom_range(0, 1));
               d_ok = 1'($urandom_range(0, 1));
            end
            push_beat(h, mi, s, d, mo, y, t_ok, d_ok);
         end
      end
   end

   always @(posedge clock) begin : drive_proc
      utc_beat_type nb;
      logic         nv;
      logic         nw;
      if (reset) begin
         req_valid  <= 1'b0;
         csr_wr_en  <= 1'b0;
         gap_cnt    = 0;
         burst_cnt  = 0;
         quiet_cnt  = 0;
         settle_cnt = 0;
      end else begin
         if (req_valid && !req_stall) begin
            local_q.push_back(local_from_utc(cur_beat, tz_offset));
         end
         nv = req_valid && req_stall;
         nw = 1'b0;
         if (local_q.size() == 0 && !req_valid) begin
            quiet_cnt++;
         end else begin
            quiet_cnt = 0;
         end
         if (settle_cnt > 0) begin
            settle_cnt--;
         end else if (!nv && pend_q.size() > 0) begin
            if (gap_cnt > 0 && hold_cnt == 0) begin
               gap_cnt--;
            end else begin
               case (pend_q[0].kind)
                  KindBeat: begin
                     cur_beat = pend_q.pop_front();
                     nv = 1'b1;
                     if (burst_cnt > 0) begin
                        burst_cnt--;
                     end else begin
                        burst_cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                                : $urandom_range(0, 12);
                        gap_cnt   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                     end
                  end
                  KindWrite: begin
                     if (quiet_cnt >= SettleCycles) begin
                        nb = pend_q.pop_front();
                        csr_wr_data <= nb.wr_value;
                        nw = 1'b1;
                        tz_offset = nb.wr_value;
                        settle_cnt = 2;
                     end
                  end
                  KindDrain: begin
                     if (local_q.size() == 0) begin
                        void'(pend_q.pop_front());
                     end
                  end
                  default: void'(pend_q.pop_front());
               endcase
            end
         end
         req_valid      <= nv;
         csr_wr_en      <= nw;
         req_utc_hour   <= cur_beat.hour;
         req_utc_minute <= cur_beat.minute;
         req_utc_second <= cur_beat.second;
         req_utc_day    <= cur_beat.day;
         req_utc_month  <= cur_beat.month;
         req_utc_year   <= cur_beat.year;
         req_time_ok    <= cur_beat.time_ok;
         req_date_ok    <= cur_beat.date_ok;
      end
   end

   always @(posedge clock) begin : sink_proc
      cta_out_type e;
      logic        ns;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_cnt  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (local_q.size() == 0) begin
               $display("%0t unexpected beat: expected none actual hour %0d day %0d",
                        $time, rsp_local_hour, rsp_local_day);
               err_cnt++;
            end else begin
               e = local_q.pop_front();
               check_field("hour", int'(e.hour), int'(rsp_local_hour));
               check_field("minute", int'(e.minute), int'(rsp_local_minute));
               check_field("second", int'(e.second), int'(rsp_local_second));
               check_field("day", int'(e.day), int'(rsp_local_day));
               check_field("month", int'(e.month), int'(rsp_local_month));
               check_field("year", int'(e.year), int'(rsp_local_year));
               check_field("time_shown", int'(e.time_ok), int'(rsp_time_shown));
               check_field("date_shown", int'(e.date_ok), int'(rsp_date_shown));
            end
            got_cnt++;
         end
         if (mode_cnt == 0) begin
            stall_mode = stall_mode_type'($urandom_range(0, 3));
            mode_cnt   = $urandom_range(8, 64);
         end else begin
            mode_cnt--;
         end
         if (!hold_done && got_cnt >= HoldAfter && pend_q.size() > 0 &&
             pend_q[0].kind == KindBeat) begin
            hold_cnt  = HoldCycles;
            hold_done = 1'b1;
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            ns = 1'b1;
         end else begin
            case (stall_mode)
               StallRandom:   ns = 1'($urandom_range(0, 1));
               StallPeriodic: ns = phase_cnt[1];
               StallHeavy:    ns = ($urandom_range(0, 4) != 0);
               default:       ns = 1'b0;
            endcase
         end
         phase_cnt++;
         rsp_stall <= ns;
      end
   end

   initial begin : finish_proc
      @(negedge reset);
      while (pend_q.size() != 0 || req_valid || local_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (TailCycles) @(negedge clock);
      if (err_cnt == 0 && local_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin : watchdog_proc
      #3_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
